/* rtl/ifsc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and CRC functions for the frame sync and CRC-32 check.
package ifsc_pkg;

   // Frame geometry
   localparam int MAX_FRAME_BYTES_DEF = 64;
   localparam int MIN_FRAME_BYTES     = 6;
   localparam int LEN_W               = 7;
   localparam int TAIL_BYTES          = 4;

   // CRC-32 (MPEG-2 form): non-reflected, all-ones seed, no final xor
   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Register file port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_FRAME_ID       = 2'd0,
      REG_FRAME_LENGTH   = 2'd1,
      REG_PAD_ZERO_BYTES = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [7:0]       sync_ident;
      logic [LEN_W-1:0] frame_length;
      logic [1:0]       pad_zero_bytes;
   } cfg_type;

   // One byte through the CRC shift register, MSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

   // Append zero to three zero bytes
   function automatic logic [31:0] crc_pad(input logic [31:0] crc, input logic [1:0] n);
      logic [31:0] z1;
      logic [31:0] z2;
      logic [31:0] z3;
      logic [31:0] r;
      z1 = crc_byte(crc, 8'h00);
      z2 = crc_byte(z1, 8'h00);
      z3 = crc_byte(z2, 8'h00);
      unique case (n)
         2'd0:    r = crc;
         2'd1:    r = z1;
         2'd2:    r = z2;
         default: r = z3;
      endcase
      return r;
   endfunction

endpackage

/* rtl/ifsc_if.sv */
`timescale 1ns / 1ps
// Byte input channel and verdict output channel interfaces.
interface ifsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        crc_ok;
   logic [31:0] computed_crc;
   logic [31:0] received_crc;

   modport source (output valid, output crc_ok, output computed_crc, output received_crc,
                   input ready);
   modport sink   (input valid, input crc_ok, input computed_crc, input received_crc,
                   output ready);
endinterface

/* rtl/ifsc_csr.sv */
`timescale 1ns / 1ps
// APB-style configuration registers: frame identifier, frame length, zero padding.
module ifsc_csr import ifsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [7:0]       sync_ident_ff;
   logic [7:0]       sync_ident_in;
   logic [LEN_W-1:0] frame_length_ff;
   logic [LEN_W-1:0] frame_length_in;
   logic [1:0]       pad_zero_bytes_ff;
   logic [1:0]       pad_zero_bytes_in;
   logic             wr_en;
   reg_idx_type      reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = reg_idx_type'(paddr[3:2]);

   // Decode the write transaction
   always_comb begin
      sync_ident_in     = sync_ident_ff;
      frame_length_in   = frame_length_ff;
      pad_zero_bytes_in = pad_zero_bytes_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FRAME_ID:       sync_ident_in     = pwdata[7:0];
            REG_FRAME_LENGTH:   frame_length_in   = pwdata[LEN_W-1:0];
            REG_PAD_ZERO_BYTES: pad_zero_bytes_in = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ident_ff     <= 8'd147;
         frame_length_ff   <= LEN_W'(38);
         pad_zero_bytes_ff <= 2'd2;
      end else begin
         sync_ident_ff     <= sync_ident_in;
         frame_length_ff   <= frame_length_in;
         pad_zero_bytes_ff <= pad_zero_bytes_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_FRAME_ID:       prdata = CSR_DATA_W'(sync_ident_ff);
         REG_FRAME_LENGTH:   prdata = CSR_DATA_W'(frame_length_ff);
         REG_PAD_ZERO_BYTES: prdata = CSR_DATA_W'(pad_zero_bytes_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.sync_ident     = sync_ident_ff;
   assign cfg.frame_length   = frame_length_ff;
   assign cfg.pad_zero_bytes = pad_zero_bytes_ff;

endmodule

/* rtl/ifsc_sync.sv */
`timescale 1ns / 1ps
// Input register, frame sync state, byte-wide CRC update and verdict register.
module ifsc_sync import ifsc_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   ifsc_req_if.sink    req,
   ifsc_rsp_if.source  rsp
);

   // Longest frame reachable through the length register
   localparam int LEN_FIELD_MAX = (2 ** LEN_W) - 1;
   localparam int LEN_MAX = (MAX_FRAME_BYTES < LEN_FIELD_MAX) ? MAX_FRAME_BYTES : LEN_FIELD_MAX;
   localparam int CNT_W   = $clog2(LEN_MAX + 1);
   localparam int CMP_W   = CNT_W + 1;
   localparam logic [LEN_W-1:0] LEN_LO = LEN_W'(MIN_FRAME_BYTES);
   localparam logic [LEN_W-1:0] LEN_HI = LEN_W'(LEN_MAX);

   // Input register
   logic             in_vld_ff;
   logic             in_vld_in;
   logic [7:0]       in_byte_ff;
   logic [7:0]       in_byte_in;

   // Sync state
   logic             locked_ff;
   logic             locked_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [31:0]      crc_ff;
   logic [31:0]      crc_in;
   logic [31:0]      tail_ff;
   logic [31:0]      tail_in;

   // Result register
   logic             out_vld_ff;
   logic             out_vld_in;
   logic             out_ok_ff;
   logic             out_ok_in;
   logic [31:0]      out_crc_ff;
   logic [31:0]      out_crc_in;
   logic [31:0]      out_rx_ff;
   logic [31:0]      out_rx_in;

   // Datapath
   logic             fire;
   logic             start;
   logic             drop;
   logic             is_body;
   logic             is_last;
   logic             emit;
   logic [LEN_W-1:0] len_clamp;
   logic [CMP_W-1:0] len_eff;
   logic [CNT_W-1:0] pos;
   logic [CMP_W-1:0] pos_x;
   logic [31:0]      crc_cur;
   logic [31:0]      tail_cur;
   logic [31:0]      crc_nx;
   logic [31:0]      tail_nx;
   logic [31:0]      crc_fin;

   // Advance the held byte when the result register is free or being drained
   assign fire      = in_vld_ff & (~out_vld_ff | rsp.ready);
   assign req.ready = ~in_vld_ff | fire;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req.ready) begin
         in_vld_in  = req.valid;
         in_byte_in = req.rx_byte;
      end
   end

   // Clamp the configured length
   always_comb begin
      priority if (cfg.frame_length < LEN_LO) begin
         len_clamp = LEN_LO;
      end else if (cfg.frame_length > LEN_HI) begin
         len_clamp = LEN_HI;
      end else begin
         len_clamp = cfg.frame_length;
      end
   end

   assign len_eff = {1'b0, len_clamp[CNT_W-1:0]};

   // Frame position and CRC / tail update for the held byte
   assign start    = ~locked_ff | (cnt_ff == '0);
   assign drop     = start & (in_byte_ff != cfg.sync_ident);
   assign pos      = start ? '0 : cnt_ff;
   assign pos_x    = {1'b0, pos};
   assign crc_cur  = start ? CRC_INIT : crc_ff;
   assign tail_cur = start ? '0 : tail_ff;
   assign is_body  = (pos_x + CMP_W'(TAIL_BYTES)) < len_eff;
   assign is_last  = (pos_x + CMP_W'(1)) >= len_eff;
   assign crc_nx   = is_body ? crc_byte(crc_cur, in_byte_ff) : crc_cur;
   assign tail_nx  = is_body ? tail_cur : {tail_cur[23:0], in_byte_ff};
   assign crc_fin  = crc_pad(crc_nx, cfg.pad_zero_bytes);
   assign emit     = ~drop & is_last;

   // Next sync state
   always_comb begin
      locked_in = locked_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      tail_in   = tail_ff;
      if (fire) begin
         priority if (drop) begin
            locked_in = 1'b0;
            cnt_in    = '0;
            crc_in    = CRC_INIT;
         end else if (is_last) begin
            locked_in = 1'b1;
            cnt_in    = '0;
            crc_in    = CRC_INIT;
            tail_in   = tail_nx;
         end else begin
            locked_in = 1'b1;
            cnt_in    = pos + CNT_W'(1);
            crc_in    = crc_nx;
            tail_in   = tail_nx;
         end
      end
   end

   // Load the verdict, hold it until taken
   always_comb begin
      out_vld_in = out_vld_ff & ~rsp.ready;
      out_ok_in  = out_ok_ff;
      out_crc_in = out_crc_ff;
      out_rx_in  = out_rx_ff;
      if (fire & emit) begin
         out_vld_in = 1'b1;
         out_ok_in  = (crc_fin == tail_nx);
         out_crc_in = crc_fin;
         out_rx_in  = tail_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         locked_ff  <= 1'b0;
         cnt_ff     <= '0;
         crc_ff     <= CRC_INIT;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         locked_ff  <= locked_in;
         cnt_ff     <= cnt_in;
         crc_ff     <= crc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      tail_ff    <= tail_in;
      out_ok_ff  <= out_ok_in;
      out_crc_ff <= out_crc_in;
      out_rx_ff  <= out_rx_in;
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.crc_ok       = out_ok_ff;
   assign rsp.computed_crc = out_crc_ff;
   assign rsp.received_crc = out_rx_ff;

`ifndef SYNTHESIS
   // Out of sync means no frame in progress
   a_hunt_idle: assert property (@(posedge clock) disable iff (reset)
      !locked_ff |-> (cnt_ff == '0))
      else $error("byte count nonzero while hunting");

   // Frame position stays inside the longest frame
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(LEN_MAX))
      else $error("byte count beyond longest frame");

   // CRC is seeded at every frame boundary
   a_crc_seed: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (crc_ff == CRC_INIT))
      else $error("CRC not seeded at frame start");

   // A verdict leaves the block locked at a frame boundary with the result loaded
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |=> (locked_ff && (cnt_ff == '0) && out_vld_ff))
      else $error("verdict without frame boundary");

   // A dropped byte leaves the block hunting
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (fire && drop) |=> !locked_ff)
      else $error("missing identifier did not drop sync");
`endif

endmodule

/* rtl/imu_frame_sync_crc32_check.sv */
`timescale 1ns / 1ps
// Top level of the frame synchronizer with CRC-32 check.
// Flow: an accepted byte is held in the input register and processed from there; a frame's
//   verdict is loaded into the result register when its last byte is processed.
// Throughput: one byte per cycle while the result channel does not stall, byte-wide CRC update.
// Reset: synchronous; clears sync, empties both registers and loads register defaults.
module imu_frame_sync_crc32_check import ifsc_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ifsc_req_if.sink              req_chan,
   ifsc_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   // Configuration registers
   ifsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Sync and check datapath
   ifsc_sync #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_sync (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule
